// File: hdl/htdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htdc_pkg
// Shared types, constants and the month-length ROM of the tabular Hijri
// date converter.
// ----------------------------------------------------------------------------
package htdc_pkg;

  localparam int OFF_W           = 17;
  localparam int ROM_YEARS       = 186;
  localparam int TABLE_YEARS_DEF = 186;

  localparam logic [21:0] START_JDN  = 22'd2396005;
  localparam logic [11:0] START_YEAR = 12'd1264;

  // Reciprocals for division by 30 (shift 23) and by 12 (shift 15)
  localparam logic [18:0] RECIP30 = 19'd279621;
  localparam logic [18:0] RECIP12 = 19'd2731;
  localparam int          SHIFT30 = 23;
  localparam int          SHIFT12 = 15;

  localparam logic [4:0] SHORT_MONTH = 5'd29;

  localparam logic REQ_TO_JDN   = 1'b0;
  localparam logic REQ_TO_HIJRI = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DAY   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [11:0] hijri_year;
    logic [3:0]  hijri_month;
    logic [4:0]  hijri_day;
    logic [21:0] jdn_in;
  } req_t;

  typedef struct packed {
    logic [21:0] jdn_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  month_length;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic             ready;
    logic [OFF_W-1:0] end_offset;
  } fill_stat_t;

  localparam logic [11:0] YEAR_MASKS [ROM_YEARS] = '{
    12'hA97, 12'hAAA, 12'hAD5, 12'h594, 12'hBAA, 12'h5B5, 12'h4B6, 12'hA57,
    12'h52B, 12'h6A3, 12'h6D1, 12'hAE9, 12'h56A, 12'hA6D, 12'h52D, 12'hC95,
    12'hE4A, 12'hEA5, 12'h6B4, 12'h9BA, 12'h53B, 12'h25B, 12'h52B, 12'hA55,
    12'hAAA, 12'hB59, 12'h574, 12'h97A, 12'h4BA, 12'hA5A, 12'hD34, 12'hEB1,
    12'h6D8, 12'hAEC, 12'h55C, 12'hA6E, 12'h536, 12'hAA6, 12'hB52, 12'hBA9,
    12'h3B4, 12'h9DA, 12'h55A, 12'hAAA, 12'hD4A, 12'hEA5, 12'h752, 12'hB69,
    12'h5B4, 12'hAAD, 12'h656, 12'hD26, 12'hE92, 12'hF49, 12'h754, 12'hB5A,
    12'h99B, 12'h49B, 12'h94B, 12'hB25, 12'hD52, 12'hD6A, 12'h56D, 12'h2B6,
    12'hA37, 12'h49B, 12'h64D, 12'h6AA, 12'hB55, 12'h35C, 12'h96E, 12'h4AF,
    12'h257, 12'h32B, 12'h595, 12'h3AA, 12'h5D9, 12'h2DA, 12'h95D, 12'h2AB,
    12'h555, 12'h6C9, 12'h6E4, 12'hB6A, 12'h5B5, 12'h2B6, 12'h996, 12'hD4A,
    12'hDC5, 12'h752, 12'h7A5, 12'h36A, 12'h9AD, 12'h54D, 12'hA95, 12'hD49,
    12'hDA5, 12'h5B2, 12'hAD5, 12'h556, 12'hA57, 12'h52B, 12'h695, 12'hB4A,
    12'hB65, 12'h56B, 12'h2AD, 12'h54E, 12'hC97, 12'h54B, 12'h6A5, 12'h6D2,
    12'hAD9, 12'h4DD, 12'h257, 12'h92D, 12'hA95, 12'hB52, 12'hB69, 12'h374,
    12'h976, 12'h4B7, 12'h257, 12'h54B, 12'h6A5, 12'h6D2, 12'hAEA, 12'h4ED,
    12'h26D, 12'h935, 12'hD25, 12'hD51, 12'hBA9, 12'h5D4, 12'hAB5, 12'h536,
    12'hA97, 12'h64A, 12'hEA5, 12'h752, 12'hBA9, 12'h5B5, 12'h2B5, 12'hA56,
    12'hD26, 12'hE53, 12'h6A9, 12'hD54, 12'hD56, 12'hA57, 12'h4A7, 12'hC47,
    12'hD26, 12'hE54, 12'hDA6, 12'h567, 12'h2B6, 12'h937, 12'h497, 12'h655,
    12'hAAA, 12'hB65, 12'h2EC, 12'h975, 12'h46E, 12'hA36, 12'hCA6, 12'hD52,
    12'hDD2, 12'h5D5, 12'h2DA, 12'h55D, 12'h4AB, 12'h693, 12'h749, 12'h7A4,
    12'hBB2, 12'h5B5, 12'h2B6, 12'h65A, 12'hD2A, 12'hE94, 12'hED1, 12'h6E8,
    12'hAEA, 12'h95C
  };

  // Long-month flag of zero-based month mon in table year yr; years past
  // the ROM read as all short months.
  function automatic logic htdc_long_month(input logic [7:0] yr, input logic [3:0] mon);
    logic [11:0] mask;
    mask = 12'd0;
    if (int'(yr) < ROM_YEARS) begin
      mask = YEAR_MASKS[yr];
    end
    return mask[4'd11 - mon];
  endfunction

endpackage

// File: hdl/htdc_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htdc_fill
// Walks the month-length ROM once after reset and streams the cumulative
// month-start offsets into the offset memory, one entry per cycle.
// ----------------------------------------------------------------------------
module htdc_fill #(
  parameter int TABLE_YEARS = htdc_pkg::TABLE_YEARS_DEF,
  parameter int AW          = $clog2(TABLE_YEARS * 12 + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [htdc_pkg::OFF_W-1:0]  wr_data_o,
  output htdc_pkg::fill_stat_t        stat_o
);
  import htdc_pkg::*;

  localparam int NUM_MONTHS = TABLE_YEARS * 12;

  logic [AW-1:0]    m_q;
  logic [3:0]       mon_q;
  logic [7:0]       yr_q;
  logic [OFF_W-1:0] acc_q;
  logic             ready_q;
  logic [OFF_W-1:0] end_q;
  logic             long_m;

  assign long_m = htdc_long_month(yr_q, mon_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q     <= '0;
      mon_q   <= '0;
      yr_q    <= '0;
      acc_q   <= '0;
      ready_q <= 1'b0;
      end_q   <= '0;
    end else if (!ready_q) begin
      if (m_q == AW'(NUM_MONTHS)) begin
        ready_q <= 1'b1;
        end_q   <= acc_q;
      end else begin
        m_q   <= m_q + 1'b1;
        acc_q <= acc_q + OFF_W'(SHORT_MONTH) + OFF_W'(long_m);
        if (mon_q == 4'd11) begin
          mon_q <= '0;
          yr_q  <= yr_q + 1'b1;
        end else begin
          mon_q <= mon_q + 1'b1;
        end
      end
    end
  end

  assign wr_en_o           = !ready_q;
  assign wr_addr_o         = m_q;
  assign wr_data_o         = acc_q;
  assign stat_o.ready      = ready_q;
  assign stat_o.end_offset = end_q;

endmodule

// File: hdl/hijri_table_date_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hijri_table_date_converter_top
// Table-driven Hijri date <-> Julian day number converter built around a
// month-start offset memory and one shared reciprocal multiplier.
// ----------------------------------------------------------------------------
// Flow: date to JDN decodes and reads the month offset; JDN to date walks
//   forward from an estimated month, up to about 36 steps, with one
//   offset-memory read per step plus its compare; out-of-table requests end at decode.
// Throughput: one transaction at a time; busy stays high until the result
//   strobe, and start is taken again in the cycle of the strobe.
// Reset: the offset memory is filled by a walk over its TABLE_YEARS*12+1
//   entries (2233 by default) with busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
module hijri_table_date_converter_top #(
  parameter int TABLE_YEARS = htdc_pkg::TABLE_YEARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  htdc_pkg::req_t req_i,
  output logic           done_o,
  output htdc_pkg::res_t res_o
);
  import htdc_pkg::*;

  localparam int NUM_MONTHS = TABLE_YEARS * 12;
  localparam int DEPTH      = NUM_MONTHS + 1;
  localparam int AW         = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_DECODE, S_H_RD, S_H_WAIT,
    S_J_MUL, S_J_EST, S_J_ISSUE, S_J_CMP, S_J_RD, S_J_FIN
  } state_e;

  state_e state_q;

  // Offset memory and its fill walker
  logic [OFF_W-1:0] offset_mem_q [DEPTH];
  logic [OFF_W-1:0] rdata_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [OFF_W-1:0] wr_data;
  fill_stat_t       fill_stat;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  htdc_fill #(
    .TABLE_YEARS(TABLE_YEARS),
    .AW         (AW)
  ) u_fill (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .stat_o   (fill_stat)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      offset_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= offset_mem_q[rd_addr];
    end
  end

  // Datapath registers
  req_t             req_q;
  logic [AW-1:0]    idx_q;
  logic [OFF_W-1:0] days_q;
  logic [4:0]       mlen_q;
  logic [35:0]      prod_q;
  res_t             res_q;
  res_t             res_d;
  logic             done_q;

  // Shared multiplier operands
  logic [OFF_W-1:0] mul_a;
  logic [18:0]      mul_b;

  // Decode terms
  logic [11:0] yoff;
  logic        h_ok;
  logic [11:0] h_idx;
  logic [21:0] jdays;
  logic        j_ok;
  logic [AW:0] nxt_idx;
  logic        nxt_ok;
  logic [12:0] est;
  logic [7:0]  q12;
  logic [11:0] rem12;

  assign yoff  = req_q.hijri_year - START_YEAR;
  assign h_ok  = (req_q.hijri_year >= START_YEAR) && ({1'b0, yoff} < 13'(TABLE_YEARS)) &&
                 (req_q.hijri_month >= 4'd1) && (req_q.hijri_month <= 4'd12);
  assign h_idx = 12'({yoff[7:0], 3'b000}) + 12'({yoff[7:0], 2'b00}) +
                 12'(req_q.hijri_month - 4'd1);
  assign jdays = req_q.jdn_in - START_JDN;
  assign j_ok  = (req_q.jdn_in >= START_JDN) && (jdays < 22'(fill_stat.end_offset));

  assign nxt_idx = {1'b0, idx_q} + 1'b1;
  assign nxt_ok  = nxt_idx < (AW + 1)'(NUM_MONTHS);
  assign est     = prod_q[35:SHIFT30];
  assign q12     = prod_q[SHIFT12+7:SHIFT12];
  assign rem12   = 12'(idx_q) - (12'({q12, 3'b000}) + 12'({q12, 2'b00}));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    mul_a   = days_q;
    mul_b   = RECIP30;
    unique case (state_q)
      S_H_RD, S_J_RD: begin
        rd_en = 1'b1;
      end
      S_J_ISSUE: begin
        rd_en   = nxt_ok;
        rd_addr = nxt_idx[AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
    if (state_q == S_J_RD) begin
      mul_a = OFF_W'(idx_q);
      mul_b = RECIP12;
    end
  end

  // Result of the current state; anything else is an out-of-table result
  always_comb begin
    res_d = '0;
    unique case (state_q)
      S_H_WAIT: begin
        res_d.month_length = mlen_q;
        if ((req_q.hijri_day >= 5'd1) && (req_q.hijri_day <= mlen_q)) begin
          res_d.jdn_out = START_JDN + 22'(rdata_q) + 22'(req_q.hijri_day) - 22'd1;
          res_d.status  = ST_OK;
        end else begin
          res_d.status  = ST_DAY;
        end
      end
      S_J_FIN: begin
        res_d.year_out  = START_YEAR + 12'(q12);
        res_d.month_out = 4'(rem12) + 4'd1;
        res_d.day_out   = 5'(days_q - rdata_q + 1'b1);
        res_d.status    = ST_OK;
      end
      default: begin
        res_d.status = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      done_q  <= 1'b0;
      req_q   <= '0;
      idx_q   <= '0;
      days_q  <= '0;
      mlen_q  <= '0;
      prod_q  <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      prod_q <= 36'(mul_a) * 36'(mul_b);
      unique case (state_q)
        S_FILL: begin
          if (fill_stat.ready) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (req_q.req_type == REQ_TO_JDN) begin
            if (h_ok) begin
              idx_q   <= AW'(h_idx);
              mlen_q  <= SHORT_MONTH +
                         5'(htdc_long_month(yoff[7:0], req_q.hijri_month - 4'd1));
              state_q <= S_H_RD;
            end else begin
              res_q   <= res_d;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end else begin
            if (j_ok) begin
              days_q  <= jdays[OFF_W-1:0];
              state_q <= S_J_MUL;
            end else begin
              res_q   <= res_d;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_H_RD: begin
          state_q <= S_H_WAIT;
        end
        S_H_WAIT: begin
          res_q   <= res_d;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_J_MUL: begin
          // product of days and 1/30 lands in prod_q
          state_q <= S_J_EST;
        end
        S_J_EST: begin
          if (est > 13'(NUM_MONTHS - 1)) begin
            idx_q <= AW'(NUM_MONTHS - 1);
          end else begin
            idx_q <= AW'(est);
          end
          state_q <= S_J_ISSUE;
        end
        S_J_ISSUE: begin
          state_q <= nxt_ok ? S_J_CMP : S_J_RD;
        end
        S_J_CMP: begin
          // advance while the next month has already started
          if (rdata_q <= days_q) begin
            idx_q   <= nxt_idx[AW-1:0];
            state_q <= S_J_ISSUE;
          end else begin
            state_q <= S_J_RD;
          end
        end
        S_J_RD: begin
          state_q <= S_J_FIN;
        end
        S_J_FIN: begin
          res_q   <= res_d;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
